// File: rtl/cdn_pkg.sv
package cdn_pkg;

    localparam int YEAR_BITS_DEF = 16;
    localparam int YEAR_BITS_MIN = 12;
    localparam int YEAR_BITS_MAX = 32;

    localparam int DAY_W   = 6;
    localparam int MONTH_W = 4;
    localparam int DAYS_W  = 5;

    localparam logic [MONTH_W-1:0] MON_JAN = 4'd1;
    localparam logic [MONTH_W-1:0] MON_FEB = 4'd2;
    localparam logic [MONTH_W-1:0] MON_MAR = 4'd3;
    localparam logic [MONTH_W-1:0] MON_APR = 4'd4;
    localparam logic [MONTH_W-1:0] MON_MAY = 4'd5;
    localparam logic [MONTH_W-1:0] MON_JUN = 4'd6;
    localparam logic [MONTH_W-1:0] MON_JUL = 4'd7;
    localparam logic [MONTH_W-1:0] MON_AUG = 4'd8;
    localparam logic [MONTH_W-1:0] MON_SEP = 4'd9;
    localparam logic [MONTH_W-1:0] MON_OCT = 4'd10;
    localparam logic [MONTH_W-1:0] MON_NOV = 4'd11;
    localparam logic [MONTH_W-1:0] MON_DEC = 4'd12;

    localparam logic [DAYS_W-1:0] DAYS_LONG  = 5'd31;
    localparam logic [DAYS_W-1:0] DAYS_SHORT = 5'd30;
    localparam logic [DAYS_W-1:0] DAYS_LEAP  = 5'd29;
    localparam logic [DAYS_W-1:0] DAYS_FEB   = 5'd28;
    localparam logic [DAYS_W-1:0] DAYS_NONE  = 5'd0;

    // Days in a month; zero for a month code outside January to December.
    function automatic logic [DAYS_W-1:0] month_days(input logic [MONTH_W-1:0] m,
                                                     input logic leap);
        logic [DAYS_W-1:0] len;
        case (m) inside
            MON_JAN, MON_MAR, MON_MAY, MON_JUL,
            MON_AUG, MON_OCT, MON_DEC:          len = DAYS_LONG;
            MON_APR, MON_JUN, MON_SEP, MON_NOV: len = DAYS_SHORT;
            MON_FEB:                            len = leap ? DAYS_LEAP : DAYS_FEB;
            default:                            len = DAYS_NONE;
        endcase
        return len;
    endfunction

    // Inverse of an odd constant modulo 2^64 by Newton steps; elaboration only.
    function automatic logic [63:0] odd_inverse(input logic [63:0] d);
        logic [63:0] x;
        x = d;
        for (int k = 0; k < 5; k++) begin
            x = x * (64'd2 - d * x);
        end
        return x;
    endfunction

endpackage

// File: rtl/cdn_if.sv
interface cdn_date_if
    import cdn_pkg::*;
#(
    parameter int YEAR_BITS = YEAR_BITS_DEF
);
    logic                 valid;
    logic                 ready;
    logic [DAY_W-1:0]     day;
    logic [MONTH_W-1:0]   month;
    logic [YEAR_BITS-1:0] year;

    modport source (output valid, output day, output month, output year, input ready);
    modport sink   (input valid, input day, input month, input year, output ready);
endinterface

interface cdn_result_if
    import cdn_pkg::*;
#(
    parameter int YEAR_BITS = YEAR_BITS_DEF
);
    logic                 valid;
    logic                 ready;
    logic                 date_valid;
    logic                 leap_year;
    logic [DAYS_W-1:0]    month_length;
    logic [DAYS_W-1:0]    prev_day;
    logic [MONTH_W-1:0]   prev_month;
    logic [YEAR_BITS-1:0] prev_year;
    logic [DAYS_W-1:0]    next_day;
    logic [MONTH_W-1:0]   next_month;
    logic [YEAR_BITS-1:0] next_year;

    modport source (output valid, output date_valid, output leap_year,
                    output month_length, output prev_day, output prev_month,
                    output prev_year, output next_day, output next_month,
                    output next_year, input ready);
    modport sink   (input valid, input date_valid, input leap_year,
                    input month_length, input prev_day, input prev_month,
                    input prev_year, input next_day, input next_month,
                    input next_year, output ready);
endinterface

// File: rtl/cdn_leap_check.sv
module cdn_leap_check
    import cdn_pkg::*;
#(
    parameter int YEAR_BITS = YEAR_BITS_DEF
) (
    input  logic [YEAR_BITS-1:0] i_year,
    output logic                 o_leap
);

    // y is a multiple of 25 exactly when y * inv(25) mod 2^N <= (2^N - 1) / 25.
    localparam logic [63:0] YEAR_MAX = (64'd1 << YEAR_BITS) - 64'd1;
    localparam logic [YEAR_BITS-1:0] INV25 = YEAR_BITS'(odd_inverse(64'd25));
    localparam logic [YEAR_BITS-1:0] LIM25 = YEAR_BITS'(YEAR_MAX / 64'd25);

    logic [YEAR_BITS-1:0] w_prod;
    logic                 w_div4;
    logic                 w_div16;
    logic                 w_div25;

    assign w_prod  = i_year * INV25;
    assign w_div25 = (w_prod <= LIM25);
    assign w_div4  = (i_year[1:0] == 2'd0);
    assign w_div16 = (i_year[3:0] == 4'd0);

    // Multiple of 4, and not of 100 unless also of 400.
    assign o_leap = w_div4 && (!w_div25 || w_div16);

endmodule

// File: rtl/cdn_neighbours.sv
module cdn_neighbours
    import cdn_pkg::*;
#(
    parameter int YEAR_BITS = YEAR_BITS_DEF
) (
    input  logic [DAY_W-1:0]     i_day,
    input  logic [MONTH_W-1:0]   i_month,
    input  logic [YEAR_BITS-1:0] i_year,
    output logic                 o_date_valid,
    output logic                 o_leap_year,
    output logic [DAYS_W-1:0]    o_month_length,
    output logic [DAYS_W-1:0]    o_prev_day,
    output logic [MONTH_W-1:0]   o_prev_month,
    output logic [YEAR_BITS-1:0] o_prev_year,
    output logic [DAYS_W-1:0]    o_next_day,
    output logic [MONTH_W-1:0]   o_next_month,
    output logic [YEAR_BITS-1:0] o_next_year
);

    localparam logic [YEAR_BITS-1:0] YEAR_TOP = '1;

    logic              w_leap;
    logic [DAYS_W-1:0] w_len;
    logic              w_valid;
    logic              w_first;
    logic              w_last;
    logic [DAYS_W-1:0] w_day5;

    cdn_leap_check #(
        .YEAR_BITS (YEAR_BITS)
    ) u_leap (
        .i_year (i_year),
        .o_leap (w_leap)
    );

    assign w_len   = month_days(i_month, w_leap);
    assign w_day5  = i_day[DAYS_W-1:0];
    assign w_valid = (i_day != '0) && (i_year != '0) && (w_len != DAYS_NONE)
                     && (i_day <= {1'b0, w_len});
    assign w_first = (i_day == DAY_W'(1));
    assign w_last  = (i_day == {1'b0, w_len});

    assign o_date_valid   = w_valid;
    assign o_leap_year    = w_leap;
    assign o_month_length = w_len;

    always_comb begin
        o_prev_day   = '0;
        o_prev_month = '0;
        o_prev_year  = '0;
        o_next_day   = '0;
        o_next_month = '0;
        o_next_year  = '0;
        if (w_valid) begin
            if (!w_first) begin
                o_prev_day   = w_day5 - DAYS_W'(1);
                o_prev_month = i_month;
                o_prev_year  = i_year;
            end else if (i_month == MON_JAN) begin
                o_prev_day   = DAYS_LONG;
                o_prev_month = MON_DEC;
                o_prev_year  = i_year - YEAR_BITS'(1);
            end else begin
                o_prev_month = i_month - MONTH_W'(1);
                o_prev_year  = i_year;
                o_prev_day   = month_days(i_month - MONTH_W'(1), w_leap);
            end

            if (!w_last) begin
                o_next_day   = w_day5 + DAYS_W'(1);
                o_next_month = i_month;
                o_next_year  = i_year;
            end else if (i_month == MON_DEC) begin
                o_next_day   = DAYS_W'(1);
                o_next_month = MON_JAN;
                o_next_year  = (i_year == YEAR_TOP) ? YEAR_TOP : i_year + YEAR_BITS'(1);
            end else begin
                o_next_day   = DAYS_W'(1);
                o_next_month = i_month + MONTH_W'(1);
                o_next_year  = i_year;
            end
        end
    end

endmodule

// File: rtl/calendar_date_neighbours_unit.sv
// Gregorian date neighbour unit. Each beat on i_date carries one date (day,
// month, year); each beat on o_result answers it with the leap-year flag, the
// month length (0 for a month outside 1..12), a date-valid flag and, for a
// valid date, the previous and following dates across month and year
// boundaries (all six neighbour fields are 0 for an invalid date). Year 0 is
// invalid; the day after 31 December of the largest year keeps that year.
// The block takes one beat per cycle while o_result is not stalled; each date
// passes through the input register, then through the date logic into the
// result register. The leap test needs one constant multiply for the
// divisible-by-25 check, which bounds the logic depth. Backpressure on
// o_result stalls both stages; i_date.ready falls only when both are full.
module calendar_date_neighbours_unit
    import cdn_pkg::*;
#(
    parameter int YEAR_BITS = YEAR_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    cdn_date_if.sink    i_date,
    cdn_result_if.source o_result
);

    // Input stage.
    logic                 r_s1_valid;
    logic                 n_s1_valid;
    logic [DAY_W-1:0]     r_day;
    logic [MONTH_W-1:0]   r_month;
    logic [YEAR_BITS-1:0] r_year;

    // Result stage.
    logic                 r_out_valid;
    logic                 n_out_valid;
    logic                 r_date_valid;
    logic                 r_leap_year;
    logic [DAYS_W-1:0]    r_month_length;
    logic [DAYS_W-1:0]    r_prev_day;
    logic [MONTH_W-1:0]   r_prev_month;
    logic [YEAR_BITS-1:0] r_prev_year;
    logic [DAYS_W-1:0]    r_next_day;
    logic [MONTH_W-1:0]   r_next_month;
    logic [YEAR_BITS-1:0] r_next_year;

    logic                 w_date_valid;
    logic                 w_leap_year;
    logic [DAYS_W-1:0]    w_month_length;
    logic [DAYS_W-1:0]    w_prev_day;
    logic [MONTH_W-1:0]   w_prev_month;
    logic [YEAR_BITS-1:0] w_prev_year;
    logic [DAYS_W-1:0]    w_next_day;
    logic [MONTH_W-1:0]   w_next_month;
    logic [YEAR_BITS-1:0] w_next_year;

    logic w_out_load;
    logic w_s1_load;
    logic w_accept;

    // Result register is free when empty or being drained this cycle.
    assign w_out_load = !r_out_valid || o_result.ready;
    // Input register may take a new beat when empty or moving forward.
    assign w_s1_load  = !r_s1_valid || w_out_load;
    assign w_accept   = i_date.valid && w_s1_load;

    assign i_date.ready = w_s1_load;

    always_comb begin
        n_s1_valid  = r_s1_valid;
        n_out_valid = r_out_valid;
        if (w_s1_load) begin
            n_s1_valid = i_date.valid;
        end
        if (w_out_load) begin
            n_out_valid = r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_s1_valid  <= n_s1_valid;
            r_out_valid <= n_out_valid;
        end
    end

    // Capture the date; hold while the stage is stalled.
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_day   <= i_date.day;
            r_month <= i_date.month;
            r_year  <= i_date.year;
        end
    end

    cdn_neighbours #(
        .YEAR_BITS (YEAR_BITS)
    ) u_calc (
        .i_day          (r_day),
        .i_month        (r_month),
        .i_year         (r_year),
        .o_date_valid   (w_date_valid),
        .o_leap_year    (w_leap_year),
        .o_month_length (w_month_length),
        .o_prev_day     (w_prev_day),
        .o_prev_month   (w_prev_month),
        .o_prev_year    (w_prev_year),
        .o_next_day     (w_next_day),
        .o_next_month   (w_next_month),
        .o_next_year    (w_next_year)
    );

    // Advance the result only when a computed beat is ready to move up.
    always_ff @(posedge i_clk) begin
        if (w_out_load && r_s1_valid) begin
            r_date_valid   <= w_date_valid;
            r_leap_year    <= w_leap_year;
            r_month_length <= w_month_length;
            r_prev_day     <= w_prev_day;
            r_prev_month   <= w_prev_month;
            r_prev_year    <= w_prev_year;
            r_next_day     <= w_next_day;
            r_next_month   <= w_next_month;
            r_next_year    <= w_next_year;
        end
    end

    assign o_result.valid        = r_out_valid;
    assign o_result.date_valid   = r_date_valid;
    assign o_result.leap_year    = r_leap_year;
    assign o_result.month_length = r_month_length;
    assign o_result.prev_day     = r_prev_day;
    assign o_result.prev_month   = r_prev_month;
    assign o_result.prev_year    = r_prev_year;
    assign o_result.next_day     = r_next_day;
    assign o_result.next_month   = r_next_month;
    assign o_result.next_year    = r_next_year;

endmodule

// File: rtl/cdn_checker.sv
module cdn_checker
    import cdn_pkg::*;
#(
    parameter int YEAR_BITS = YEAR_BITS_DEF
) (
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 i_out_valid,
    input logic                 i_out_ready,
    input logic                 i_date_valid,
    input logic                 i_leap_year,
    input logic [DAYS_W-1:0]    i_month_length,
    input logic [DAYS_W-1:0]    i_prev_day,
    input logic [MONTH_W-1:0]   i_prev_month,
    input logic [YEAR_BITS-1:0] i_prev_year,
    input logic [DAYS_W-1:0]    i_next_day,
    input logic [MONTH_W-1:0]   i_next_month,
    input logic [YEAR_BITS-1:0] i_next_year
);

    // A stalled result beat stays valid and keeps its years and date-valid flag.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_next_year)
            && $stable(i_prev_year) && $stable(i_date_valid))
        else $error("result beat changed while stalled");

    // Invalid dates carry no neighbours.
    a_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_date_valid |-> i_prev_day == '0 && i_prev_month == '0
            && i_prev_year == '0 && i_next_day == '0 && i_next_month == '0
            && i_next_year == '0)
        else $error("neighbour fields set for an invalid date");

    // Valid dates have real neighbour days and months.
    a_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_date_valid |-> i_prev_day != '0 && i_next_day != '0
            && i_prev_month != '0 && i_next_month != '0
            && i_prev_month <= MON_DEC && i_next_month <= MON_DEC)
        else $error("neighbour date out of range");

    // A 29-day month only appears in a leap year.
    a_leap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_month_length == DAYS_LEAP |-> i_leap_year)
        else $error("29-day February in a common year");

endmodule

bind calendar_date_neighbours_unit cdn_checker #(
    .YEAR_BITS (YEAR_BITS)
) u_cdn_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_out_valid    (o_result.valid),
    .i_out_ready    (o_result.ready),
    .i_date_valid   (o_result.date_valid),
    .i_leap_year    (o_result.leap_year),
    .i_month_length (o_result.month_length),
    .i_prev_day     (o_result.prev_day),
    .i_prev_month   (o_result.prev_month),
    .i_prev_year    (o_result.prev_year),
    .i_next_day     (o_result.next_day),
    .i_next_month   (o_result.next_month),
    .i_next_year    (o_result.next_year)
);
